// ----- design/k_smallest_sum_tracker_defines.svh -----
// Assertion macros used by the tracker RTL (kst_total).
`ifndef K_SMALLEST_SUM_TRACKER_DEFINES_SVH
`define K_SMALLEST_SUM_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kst: implication check failed");
// next-cycle implication
`define KST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kst: next-cycle check failed");
`else
`define KST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/kst_pkg.sv -----
package kst_pkg;

  localparam int MAX_K  = 64;
  localparam int WORD_W = 64;
  localparam int STEP_W = 48;
  localparam int VAL_W  = 40;
  localparam int KCFG_W = 7;
  localparam int CNT_W  = $clog2(MAX_K + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam word_t WORD_POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  // value entering the chain, with the offset it was taken against
  typedef struct packed {
    logic  vld;
    word_t value;
    word_t offset;
  } ins_beat_t;

  // chain result handed to the sum stage
  typedef struct packed {
    logic  vld;
    logic  full;
    word_t delta;
    word_t offset;
  } upd_beat_t;

  // one result beat
  typedef struct packed {
    word_t total;
    logic  ready_res;
  } out_beat_t;

  // k_count clamped to 1..MAX_K
  function automatic count_t clamp_k(input logic [KCFG_W-1:0] k);
    count_t r;
    if (k == '0) begin
      r = CNT_W'(1);
    end else if (int'(k) > MAX_K) begin
      r = CNT_W'(MAX_K);
    end else begin
      r = CNT_W'(k);
    end
    return r;
  endfunction

endpackage

// ----- design/kst_channels.sv -----
// Input item channel
interface kst_in_if;
  logic                        valid;
  logic                        ready;
  logic [kst_pkg::STEP_W-1:0]  offset_step;
  logic [kst_pkg::VAL_W-1:0]   new_value;

  modport source (output valid, output offset_step, output new_value, input ready);
  modport sink   (input valid, input offset_step, input new_value, output ready);
endinterface

// Result channel
interface kst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kst_pkg::WORD_W-1:0] total;
  logic                              ready_res;

  modport source (output valid, output total, output ready_res, input ready);
  modport sink   (input valid, input total, input ready_res, output ready);
endinterface

// Configuration write channel (k_count)
interface kst_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kst_pkg::KCFG_W-1:0]  k_count;

  modport source (output valid, output k_count, input ready);
  modport sink   (input valid, input k_count, output ready);
endinterface

// ----- design/kst_front.sv -----
module kst_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       clear,
  input  logic                       in_fire,
  input  logic [kst_pkg::STEP_W-1:0] offset_step,
  input  logic [kst_pkg::VAL_W-1:0]  new_value,
  output kst_pkg::ins_beat_t         ins_o
);
  import kst_pkg::*;

  logic              vld1_r;
  logic [STEP_W-1:0] step1_r;
  logic [VAL_W-1:0]  nv1_r;
  logic              vld2_r;
  logic [VAL_W-1:0]  nv2_r;
  word_t             off_acc_r;
  word_t             off_acc_nxt;
  logic              ins_vld_r;
  word_t             ins_val_r;
  word_t             ins_off_r;

  // running offset; while an item sits in stage 2 this is its own offset
  assign off_acc_nxt = off_acc_r + WORD_W'(step1_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      ins_vld_r <= 1'b0;
      off_acc_r <= '0;
    end else begin
      if (en) begin
        vld1_r    <= in_fire;
        vld2_r    <= vld1_r;
        ins_vld_r <= vld2_r;
      end
      if (clear) begin
        off_acc_r <= '0;
      end else if (en && vld1_r) begin
        off_acc_r <= off_acc_nxt;
      end
    end
  end

  // payload: input reg, then value with the offset taken out
  always_ff @(posedge clk) begin
    if (en) begin
      step1_r   <= offset_step;
      nv1_r     <= new_value;
      nv2_r     <= nv1_r;
      ins_val_r <= WORD_W'(nv2_r) - off_acc_r;
      ins_off_r <= off_acc_r;
    end
  end

  assign ins_o = '{vld: ins_vld_r, value: ins_val_r, offset: ins_off_r};

endmodule

// ----- design/kst_chain.sv -----
module kst_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               clear,
  input  kst_pkg::count_t    k_eff,
  input  kst_pkg::ins_beat_t ins_i,
  output kst_pkg::upd_beat_t upd_o
);
  import kst_pkg::*;

  // chain kept in descending order: cell 0 holds the largest kept value
  word_t      cell_r   [MAX_K];
  word_t      cell_nxt [MAX_K];
  count_t     cnt_r;
  count_t     cnt_nxt;
  logic [MAX_K:0] gt;
  logic [MAX_K:0] gt_sh;
  logic       full;
  logic       drop;
  word_t      v;
  word_t      delta_nxt;
  logic       upd_vld_r;
  logic       upd_full_r;
  word_t      upd_delta_r;
  word_t      upd_off_r;

  assign v      = ins_i.value;
  assign full   = (cnt_r >= k_eff);
  assign gt[MAX_K] = 1'b0;
  assign gt_sh  = {gt[MAX_K-1:0], 1'b1};
  assign drop   = full && gt[0];

  // per-cell compare and neighbor select
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    word_t from_lo;
    word_t from_hi;

    if (i == 0) begin : g_lo0
      assign from_lo = v;
    end else begin : g_lo
      assign from_lo = cell_r[i-1];
    end
    if (i == MAX_K - 1) begin : g_hi_end
      assign from_hi = cell_r[i];
    end else begin : g_hi
      assign from_hi = cell_r[i+1];
    end

    assign gt[i] = (CNT_W'(i) < cnt_r) && ($signed(cell_r[i]) > $signed(v));

    always_comb begin
      if (!full) begin
        // open a slot at the first cell not above v, rest move up one
        if (gt[i]) begin
          cell_nxt[i] = cell_r[i];
        end else if (gt_sh[i]) begin
          cell_nxt[i] = v;
        end else begin
          cell_nxt[i] = from_lo;
        end
      end else if (drop) begin
        // cell 0 leaves, larger values move down, v lands below them
        if (gt[i+1]) begin
          cell_nxt[i] = from_hi;
        end else if (gt[i]) begin
          cell_nxt[i] = v;
        end else begin
          cell_nxt[i] = cell_r[i];
        end
      end else begin
        cell_nxt[i] = cell_r[i];
      end
    end
  end

  assign cnt_nxt   = full ? cnt_r : cnt_r + 1'b1;
  assign delta_nxt = !full ? v : (drop ? v - cell_r[0] : '0);

  // chain storage
  always_ff @(posedge clk) begin
    if (en && ins_i.vld) begin
      for (int i = 0; i < MAX_K; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  end

  // fill count and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      upd_vld_r <= 1'b0;
    end else begin
      if (clear) begin
        cnt_r <= '0;
      end else if (en && ins_i.vld) begin
        cnt_r <= cnt_nxt;
      end
      if (en) begin
        upd_vld_r <= ins_i.vld;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      upd_full_r  <= (cnt_nxt >= k_eff);
      upd_delta_r <= delta_nxt;
      upd_off_r   <= ins_i.offset;
    end
  end

  assign upd_o = '{vld: upd_vld_r, full: upd_full_r, delta: upd_delta_r, offset: upd_off_r};

endmodule

// ----- design/kst_total.sv -----
`include "k_smallest_sum_tracker_defines.svh"

module kst_total (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  kst_pkg::count_t    k_eff,
  input  kst_pkg::upd_beat_t upd_i,
  input  logic               out_ready,
  output logic               en,
  output logic               out_valid,
  output kst_pkg::out_beat_t out_beat
);
  import kst_pkg::*;

  logic                    vld5_r;
  logic                    rdy5_r;
  word_t                   prod5_r;
  word_t                   sum_acc_r;
  word_t                   sum_acc_nxt;
  logic [WORD_W+CNT_W-1:0] prod_w;
  out_beat_t               res_nxt;
  logic                    new_item;
  logic                    out_valid_r;
  logic                    skid_valid_r;
  out_beat_t               out_beat_r;
  out_beat_t               skid_beat_r;

  // pipeline moves unless the skid slot is taken
  assign en = !skid_valid_r;

  assign sum_acc_nxt = sum_acc_r + upd_i.delta;
  assign prod_w      = upd_i.offset * k_eff;

  // running sum; while an item sits in stage 5 this is its own sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r    <= 1'b0;
      sum_acc_r <= '0;
    end else begin
      if (en) begin
        vld5_r <= upd_i.vld;
      end
      if (clear) begin
        sum_acc_r <= '0;
      end else if (en && upd_i.vld) begin
        sum_acc_r <= sum_acc_nxt;
      end
    end
  end

  // offset times k, registered before the final add
  always_ff @(posedge clk) begin
    if (en) begin
      prod5_r <= prod_w[WORD_W-1:0];
      rdy5_r  <= upd_i.full;
    end
  end

  always_comb begin
    res_nxt.ready_res = rdy5_r;
    res_nxt.total     = rdy5_r ? sum_acc_r + prod5_r : WORD_POS_MAX;
  end

  assign new_item = en && vld5_r;

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_ready) begin
        if (new_item) begin
          skid_valid_r <= 1'b1;
        end
      end else if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= new_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (new_item) begin
        skid_beat_r <= res_nxt;
      end
    end else if (skid_valid_r) begin
      out_beat_r <= skid_beat_r;
    end else if (new_item) begin
      out_beat_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // checks
  `KST_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r)
  `KST_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_valid_r && out_ready, out_valid_r && !skid_valid_r)
  `KST_ASSERT_NXT(a_stall_parks, clk, rst_n, !skid_valid_r && out_valid_r && !out_ready && vld5_r, skid_valid_r)
  `KST_ASSERT_IMP(a_not_ready_max, clk, rst_n, out_valid_r && !out_beat_r.ready_res, out_beat_r.total == WORD_POS_MAX)

endmodule

// ----- design/k_smallest_sum_tracker.sv -----
// Throughput: one item per cycle while the skid slot is empty.
// The chain of compare cells settles one insert per cycle while the pipeline moves.
// Output stalls are absorbed by a skid slot; input ready drops only while it is full.
// Reset (rst_n low, synchronous): k = 1, tracker cleared, pipeline and output empty.
// A k_count write also clears the held values, running sum and total offset.
module k_smallest_sum_tracker (
  input  logic      clk,
  input  logic      rst_n,
  kst_in_if.sink    in_ch,
  kst_out_if.source out_ch,
  kst_cfg_if.sink   cfg_ch
);
  import kst_pkg::*;

  count_t    k_eff_r;
  logic      clear;
  logic      en;
  logic      in_fire;
  ins_beat_t ins_beat;
  upd_beat_t upd_beat;
  out_beat_t res_beat;
  logic      res_valid;

  // configuration: always ready, write restarts the tracker
  assign cfg_ch.ready = 1'b1;
  assign clear        = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_eff_r <= CNT_W'(1);
    end else if (clear) begin
      k_eff_r <= clamp_k(cfg_ch.k_count);
    end
  end

  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  kst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .clear       (clear),
    .in_fire     (in_fire),
    .offset_step (in_ch.offset_step),
    .new_value   (in_ch.new_value),
    .ins_o       (ins_beat)
  );

  kst_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .clear (clear),
    .k_eff (k_eff_r),
    .ins_i (ins_beat),
    .upd_o (upd_beat)
  );

  kst_total u_total (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .k_eff     (k_eff_r),
    .upd_i     (upd_beat),
    .out_ready (out_ch.ready),
    .en        (en),
    .out_valid (res_valid),
    .out_beat  (res_beat)
  );

  assign out_ch.valid     = res_valid;
  assign out_ch.total     = $signed(res_beat.total);
  assign out_ch.ready_res = res_beat.ready_res;

endmodule
